FILE: rtl/ycmd_pkg.sv
`timescale 1ns / 1ps

package ycmd_pkg;

    localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;

    localparam int HEADING_W   = 15;
    localparam int ERR_W       = 16;
    localparam int GAIN_W      = 15;
    localparam int LIMIT_W     = 14;
    localparam int RATE_W      = 15;
    localparam int SPEED_W     = 16;
    localparam int DECAY_W     = 16;
    localparam int SQ_W        = 2 * LIMIT_W;
    localparam int X_W         = DECAY_W + SQ_W;
    localparam int IDX_W       = 14;
    localparam int EXP_W       = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic signed [ERR_W-1:0] PI_Q     = 16'sd12868;
    localparam logic signed [ERR_W-1:0] NEG_PI_Q = -16'sd12868;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q = 16'sd25736;

    localparam logic [63:0] EXP_STEP_K = 64'd1040706261;

    localparam logic [GAIN_W-1:0]  YAW_GAIN_RST       = 15'd14746;
    localparam logic [LIMIT_W-1:0] YAW_RATE_LIMIT_RST = 14'd8042;

    localparam logic [CFG_INDEX_W-1:0] REG_YAW_GAIN        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_YAW_RATE_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_AMPLITUDE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_DECAY     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_OFFSET    = 3'd4;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate;
        logic [LIMIT_W-1:0]       mag;
        logic                     clamped;
    } rate_item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] amplitude;
        logic [DECAY_W-1:0]        decay;
        logic signed [SPEED_W-1:0] offset;
    } speed_cfg_t;

    // Entry i holds exp(-i/32) in Q.12, built by repeated fixed-point steps.
    function automatic logic [EXP_W-1:0] exp_entry(input int unsigned idx);
        logic [63:0] v;
        logic [63:0] r;
        v = 64'd1 << 30;
        for (int unsigned k = 0; k < idx; k++)
        begin
            v = (v * EXP_STEP_K + (64'd1 << 29)) >> 30;
        end
        r = (v + (64'd1 << 17)) >> 18;
        return r[EXP_W-1:0];
    endfunction

endpackage

FILE: rtl/ycmd_rate.sv
`timescale 1ns / 1ps

module ycmd_rate (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [ycmd_pkg::GAIN_W-1:0]           gain,
    input  logic [ycmd_pkg::LIMIT_W-1:0]          limit,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ycmd_pkg::HEADING_W-1:0] target,
    input  logic signed [ycmd_pkg::HEADING_W-1:0] measured,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output ycmd_pkg::rate_item_t                  out_item
);

    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;

    logic signed [ycmd_pkg::ERR_W-1:0] diff;
    logic signed [ycmd_pkg::ERR_W-1:0] err_next, err_reg;
    logic signed [ycmd_pkg::ERR_W-1:0] gain_s;
    logic signed [31:0]                prod_next, prod_reg;
    logic                              neg;
    logic [31:0]                       abs_p;
    logic [31:0]                       abs_sum;
    logic [17:0]                       rnd;
    logic                              clamp;
    logic [ycmd_pkg::LIMIT_W-1:0]      mag;
    ycmd_pkg::rate_item_t              item_next, item_reg;

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_comb
    begin
        diff = {target[ycmd_pkg::HEADING_W-1], target}
             - {measured[ycmd_pkg::HEADING_W-1], measured};
        if (diff < ycmd_pkg::NEG_PI_Q)
        begin
            err_next = diff + ycmd_pkg::TWO_PI_Q;
        end
        else if (diff > ycmd_pkg::PI_Q)
        begin
            err_next = diff - ycmd_pkg::TWO_PI_Q;
        end
        else
        begin
            err_next = diff;
        end
    end

    assign gain_s    = {1'b0, gain};
    assign prod_next = gain_s * err_reg;

    always_comb
    begin
        neg     = prod_reg[31];
        abs_p   = neg ? 32'(-prod_reg) : 32'(prod_reg);
        abs_sum = abs_p + 32'd8192;
        rnd     = abs_sum[31:14];
        clamp   = rnd > {4'b0, limit};
        mag     = clamp ? limit : rnd[ycmd_pkg::LIMIT_W-1:0];
        item_next.mag     = mag;
        item_next.clamped = clamp;
        item_next.rate    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            err_reg <= err_next;
        end
        if (ready2 && v1_reg)
        begin
            prod_reg <= prod_next;
        end
        if (ready3 && v2_reg)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/ycmd_exp_rom.sv
`timescale 1ns / 1ps

module ycmd_exp_rom #(
    parameter int unsigned DEPTH  = ycmd_pkg::EXP_TABLE_DEPTH_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       hit,
    input  logic [ADDR_W-1:0]          addr,
    output logic [ycmd_pkg::EXP_W-1:0] data
);

    logic [ycmd_pkg::EXP_W-1:0] rom_table [DEPTH];
    logic [ycmd_pkg::EXP_W-1:0] data_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        assign rom_table[g] = ycmd_pkg::exp_entry(g);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= hit ? rom_table[addr] : '0;
        end
    end

    assign data = data_reg;

endmodule

FILE: rtl/ycmd_speed.sv
`timescale 1ns / 1ps

module ycmd_speed #(
    parameter int unsigned EXP_TABLE_DEPTH = ycmd_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ycmd_pkg::speed_cfg_t                cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ycmd_pkg::rate_item_t                in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ycmd_pkg::SPEED_W-1:0] speed,
    output ycmd_pkg::rate_item_t                out_item
);

    localparam int unsigned ADDR_W = $clog2(EXP_TABLE_DEPTH);
    localparam logic [ycmd_pkg::IDX_W-1:0] DEPTH_V = ycmd_pkg::IDX_W'(EXP_TABLE_DEPTH);

    logic v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic ready4, ready5, ready6, ready7, ready8;

    ycmd_pkg::rate_item_t item4_reg, item5_reg, item6_reg, item7_reg, item8_reg;

    logic [ycmd_pkg::SQ_W-1:0]  sq_next, sq_reg;
    logic [ycmd_pkg::X_W-1:0]   x_next, x_reg;
    logic [ycmd_pkg::X_W:0]     x_sum;
    logic [ycmd_pkg::IDX_W-1:0] idx;
    logic                       hit;
    logic [ADDR_W-1:0]          addr;
    logic [ycmd_pkg::EXP_W-1:0] e_val;
    logic signed [ycmd_pkg::EXP_W:0] e_s;
    logic signed [29:0]         p_next, p_reg;
    logic                       neg;
    logic [29:0]                abs_p;
    logic [29:0]                abs_sum;
    logic [17:0]                rnd;
    logic signed [18:0]         total;
    logic signed [ycmd_pkg::SPEED_W-1:0] speed_next, speed_reg;

    assign ready8   = !v8_reg || out_ready;
    assign ready7   = !v7_reg || ready8;
    assign ready6   = !v6_reg || ready7;
    assign ready5   = !v5_reg || ready6;
    assign ready4   = !v4_reg || ready5;
    assign in_ready = ready4;

    assign sq_next = in_item.mag * in_item.mag;
    assign x_next  = cfg.decay * sq_reg;

    always_comb
    begin
        x_sum = {1'b0, x_reg} + (ycmd_pkg::X_W + 1)'(64'd1 << 30);
        idx   = x_sum[ycmd_pkg::X_W:31];
        hit   = idx < DEPTH_V;
        addr  = hit ? idx[ADDR_W-1:0] : '0;
    end

    ycmd_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .en   (ready6 && v5_reg),
        .hit  (hit),
        .addr (addr),
        .data (e_val)
    );

    assign e_s    = {1'b0, e_val};
    assign p_next = cfg.amplitude * e_s;

    always_comb
    begin
        neg     = p_reg[29];
        abs_p   = neg ? 30'(-p_reg) : 30'(p_reg);
        abs_sum = abs_p + 30'd2048;
        rnd     = abs_sum[29:12];
        total   = (neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd}))
                + 19'(cfg.offset);
        if (total > 19'sd32767)
        begin
            speed_next = 16'sh7FFF;
        end
        else if (total < -19'sd32768)
        begin
            speed_next = 16'sh8000;
        end
        else
        begin
            speed_next = total[ycmd_pkg::SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            if (ready4)
            begin
                v4_reg <= in_valid;
            end
            if (ready5)
            begin
                v5_reg <= v4_reg;
            end
            if (ready6)
            begin
                v6_reg <= v5_reg;
            end
            if (ready7)
            begin
                v7_reg <= v6_reg;
            end
            if (ready8)
            begin
                v8_reg <= v7_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4 && in_valid)
        begin
            item4_reg <= in_item;
            sq_reg    <= sq_next;
        end
        if (ready5 && v4_reg)
        begin
            item5_reg <= item4_reg;
            x_reg     <= x_next;
        end
        if (ready6 && v5_reg)
        begin
            item6_reg <= item5_reg;
        end
        if (ready7 && v6_reg)
        begin
            item7_reg <= item6_reg;
            p_reg     <= p_next;
        end
        if (ready8 && v7_reg)
        begin
            item8_reg <= item7_reg;
            speed_reg <= speed_next;
        end
    end

    assign out_valid = v8_reg;
    assign out_item  = item8_reg;
    assign speed     = speed_reg;

endmodule

FILE: rtl/yaw_rate_speed_command_unit.sv
`timescale 1ns / 1ps

// Proportional yaw controller with a Gaussian forward-speed law. The block
// accepts one heading pair per clock while the output side does not stall
// and returns one result per pair. It is built as an eight-stage pipeline:
// heading error and wrap, gain multiply, rounding and clamp, rate squared,
// decay multiply, exponential table read, amplitude multiply, and rounding
// with offset and saturation. Any empty stage lets the pipeline take a new
// transfer, so s_tready stays high whenever the output register is empty or
// being drained. Registers are written through the cfg port, which is always
// ready, and must only be written while no item is in flight.

module yaw_rate_speed_command_unit #(
    parameter int unsigned EXP_TABLE_DEPTH = ycmd_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // target_heading [14:0], measured_heading [29:15], zero [31:30]
    input  logic [31:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // forward_speed [15:0], yaw_rate_cmd [30:16], zero [31]
    output logic [31:0]                         m_tdata,
    // rate_clamped [0]
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ycmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ycmd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [ycmd_pkg::GAIN_W-1:0]  yaw_gain_reg;
    logic [ycmd_pkg::LIMIT_W-1:0] yaw_rate_limit_reg;
    ycmd_pkg::speed_cfg_t         speed_cfg_reg;

    logic                 mid_valid;
    logic                 mid_ready;
    ycmd_pkg::rate_item_t mid_item;
    ycmd_pkg::rate_item_t out_item;
    logic signed [ycmd_pkg::SPEED_W-1:0] forward_speed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_gain_reg            <= ycmd_pkg::YAW_GAIN_RST;
            yaw_rate_limit_reg      <= ycmd_pkg::YAW_RATE_LIMIT_RST;
            speed_cfg_reg.amplitude <= '0;
            speed_cfg_reg.decay     <= '0;
            speed_cfg_reg.offset    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ycmd_pkg::REG_YAW_GAIN:
                    yaw_gain_reg <= cfg_data[ycmd_pkg::GAIN_W-1:0];
                ycmd_pkg::REG_YAW_RATE_LIMIT:
                    yaw_rate_limit_reg <= cfg_data[ycmd_pkg::LIMIT_W-1:0];
                ycmd_pkg::REG_SPEED_AMPLITUDE:
                    speed_cfg_reg.amplitude <= cfg_data;
                ycmd_pkg::REG_SPEED_DECAY:
                    speed_cfg_reg.decay <= cfg_data;
                ycmd_pkg::REG_SPEED_OFFSET:
                    speed_cfg_reg.offset <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ycmd_rate u_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (yaw_gain_reg),
        .limit     (yaw_rate_limit_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .target    (s_tdata[14:0]),
        .measured  (s_tdata[29:15]),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_item  (mid_item)
    );

    ycmd_speed #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (speed_cfg_reg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_item   (mid_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .speed     (forward_speed),
        .out_item  (out_item)
    );

    assign m_tdata = {1'b0, out_item.rate, forward_speed};
    assign m_tuser = out_item.clamped;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

    a_rate_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[30:16] != 15'h4000)
        else $error("yaw rate command beyond the limit range");

endmodule
